[src/gps_acquire_retry_sequencer_core_assert.svh]
// assertion macros for the sequencer checker
`ifndef GPS_ACQUIRE_RETRY_SEQUENCER_CORE_ASSERT_SVH
`define GPS_ACQUIRE_RETRY_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define GARS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define GARS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/gars_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_pkg
// Types, codes and helpers shared by the GPS acquire/retry sequencer.
// ----------------------------------------------------------------------------
package gars_pkg;

  // phase codes
  localparam logic [2:0] PH_VERIFY  = 3'd0;
  localparam logic [2:0] PH_ACQUIRE = 3'd1;
  localparam logic [2:0] PH_STORE   = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  // receiver reset kinds
  localparam logic [1:0] KIND_HOT  = 2'd0;
  localparam logic [1:0] KIND_WARM = 2'd1;
  localparam logic [1:0] KIND_COLD = 2'd2;

  // register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_MAX_VERIFY  = 3'd0;
  localparam logic [2:0] REG_MAX_ACQUIRE = 3'd1;
  localparam logic [2:0] REG_WAIT_SEC    = 3'd2;
  localparam logic [2:0] REG_COLD_SEC    = 3'd3;
  localparam logic [2:0] REG_WARM_SEC    = 3'd4;
  localparam logic [2:0] REG_HOT_SEC     = 3'd5;

  // register reset values
  localparam logic [7:0] RST_MAX_VERIFY  = 8'd5;
  localparam logic [7:0] RST_MAX_ACQUIRE = 8'd3;
  localparam logic [7:0] RST_WAIT_SEC    = 8'd10;
  localparam logic [7:0] RST_COLD_SEC    = 8'd5;
  localparam logic [7:0] RST_WARM_SEC    = 8'd3;
  localparam logic [7:0] RST_HOT_SEC     = 8'd2;

  localparam logic [7:0] CNT_MAX = 8'hff;

  typedef struct packed {
    logic [7:0] max_verify_retries;
    logic [7:0] max_acquire_retries;
    logic [7:0] wait_seconds;
    logic [7:0] cold_seconds;
    logic [7:0] warm_seconds;
    logic [7:0] hot_seconds;
  } cfg_t;

  typedef struct packed {
    logic [7:0] receiver_status;
    logic       acquire_ok;
    logic       fix_nonzero;
    logic       store_ok;
    logic       timer_done;
  } tick_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       power_on_pulse;
    logic       timer_start;
    logic [7:0] timer_length;
    logic       reset_request;
    logic [1:0] reset_kind;
    logic       save_request;
    logic [7:0] verify_retries;
    logic [7:0] acquire_retries;
  } res_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] verify_count;
    logic [7:0] acquire_count;
    logic [7:0] last_status;
    logic [1:0] last_reset_kind;
  } state_t;

  // saturating increment
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == CNT_MAX) ? v : v + 8'd1;
  endfunction

  // divisible by three: base-4 digit sum keeps the residue mod 3
  function automatic logic mod3_zero(input logic [7:0] v);
    logic [3:0] s;
    logic       z;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: z = 1'b1;
      default:                       z = 1'b0;
    endcase
    return z;
  endfunction

endpackage

[src/gars_tick_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_tick_if
// Poll tick channel: valid/ready with the receiver status fields.
// ----------------------------------------------------------------------------
interface gars_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] receiver_status;
  logic       acquire_ok;
  logic       fix_nonzero;
  logic       store_ok;
  logic       timer_done;

  modport source (
    output valid, receiver_status, acquire_ok, fix_nonzero, store_ok, timer_done,
    input  ready
  );
  modport sink (
    input  valid, receiver_status, acquire_ok, fix_nonzero, store_ok, timer_done,
    output ready
  );
endinterface

[src/gars_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_result_if
// Result channel: valid/ready with the sequencer action fields.
// ----------------------------------------------------------------------------
interface gars_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] state_code;
  logic       power_on_pulse;
  logic       timer_start;
  logic [7:0] timer_length;
  logic       reset_request;
  logic [1:0] reset_kind;
  logic       save_request;
  logic [7:0] verify_retries;
  logic [7:0] acquire_retries;

  modport source (
    output valid, state_code, power_on_pulse, timer_start, timer_length,
           reset_request, reset_kind, save_request, verify_retries, acquire_retries,
    input  ready
  );
  modport sink (
    input  valid, state_code, power_on_pulse, timer_start, timer_length,
           reset_request, reset_kind, save_request, verify_retries, acquire_retries,
    output ready
  );
endinterface

[src/gps_acquire_retry_sequencer_core.sv]
`timescale 1ns / 1ps
// Once its tick request is accepted, a result passes the input register, then
// the result register behind the next-state logic; a stall can hold either.
// One tick request is taken per cycle while the result channel does not stall.
// Ready follows the result register: it drops only while both stages hold.
// Reset (rst, synchronous): phase verify, counters and last status zero,
// last reset kind hot, registers at their defaults, both stages empty.
// ----------------------------------------------------------------------------
// gps_acquire_retry_sequencer_core
// GPS acquire/retry sequencer top: tick register, state logic, result register.
// ----------------------------------------------------------------------------
module gps_acquire_retry_sequencer_core (
  input  logic                        clk,
  input  logic                        rst,
  gars_tick_if.sink                   tick,
  gars_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gars_pkg::ADDR_W-1:0] paddr,
  input  logic [gars_pkg::DATA_W-1:0] pwdata,
  output logic [gars_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import gars_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  tick_t  tick_q;
  logic   tick_vld;
  res_t   res_next;
  res_t   res_q;
  logic   res_vld;
  logic   advance;
  logic   take;

  // configuration registers
  gars_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake control
  assign advance    = !res_vld || result.ready;
  assign tick.ready = !tick_vld || advance;
  assign take       = tick.valid && tick.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= 1'b0;
    end else if (take) begin
      tick_vld <= 1'b1;
    end else if (advance) begin
      tick_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tick_q.receiver_status <= tick.receiver_status;
      tick_q.acquire_ok      <= tick.acquire_ok;
      tick_q.fix_nonzero     <= tick.fix_nonzero;
      tick_q.store_ok        <= tick.store_ok;
      tick_q.timer_done      <= tick.timer_done;
    end
  end

  // next-state logic
  gars_step u_step (
    .cfg (cfg),
    .cur (st),
    .tk  (tick_q),
    .nxt (st_next),
    .res (res_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase           <= PH_VERIFY;
      st.verify_count    <= 8'd0;
      st.acquire_count   <= 8'd0;
      st.last_status     <= 8'd0;
      st.last_reset_kind <= KIND_HOT;
    end else if (tick_vld && advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= tick_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_vld && advance) begin
      res_q <= res_next;
    end
  end

  // result channel
  assign result.valid           = res_vld;
  assign result.state_code      = res_q.state_code;
  assign result.power_on_pulse  = res_q.power_on_pulse;
  assign result.timer_start     = res_q.timer_start;
  assign result.timer_length    = res_q.timer_length;
  assign result.reset_request   = res_q.reset_request;
  assign result.reset_kind      = res_q.reset_kind;
  assign result.save_request    = res_q.save_request;
  assign result.verify_retries  = res_q.verify_retries;
  assign result.acquire_retries = res_q.acquire_retries;

endmodule

[src/gars_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_regs
// APB register bank holding the retry limits and timer lengths.
// ----------------------------------------------------------------------------
module gars_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gars_pkg::ADDR_W-1:0] paddr,
  input  logic [gars_pkg::DATA_W-1:0] pwdata,
  output logic [gars_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gars_pkg::cfg_t             cfg
);
  import gars_pkg::*;

  logic [2:0] index;
  logic       wr_en;
  logic [7:0] wdata;
  logic [7:0] rdata;

  // word index and write strobe
  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[7:0];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_verify_retries  <= RST_MAX_VERIFY;
      cfg.max_acquire_retries <= RST_MAX_ACQUIRE;
      cfg.wait_seconds        <= RST_WAIT_SEC;
      cfg.cold_seconds        <= RST_COLD_SEC;
      cfg.warm_seconds        <= RST_WARM_SEC;
      cfg.hot_seconds         <= RST_HOT_SEC;
    end else if (wr_en) begin
      unique case (index)
        REG_MAX_VERIFY:  cfg.max_verify_retries  <= wdata;
        REG_MAX_ACQUIRE: cfg.max_acquire_retries <= wdata;
        REG_WAIT_SEC:    cfg.wait_seconds        <= wdata;
        REG_COLD_SEC:    cfg.cold_seconds        <= wdata;
        REG_WARM_SEC:    cfg.warm_seconds        <= wdata;
        REG_HOT_SEC:     cfg.hot_seconds         <= wdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (index)
      REG_MAX_VERIFY:  rdata = cfg.max_verify_retries;
      REG_MAX_ACQUIRE: rdata = cfg.max_acquire_retries;
      REG_WAIT_SEC:    rdata = cfg.wait_seconds;
      REG_COLD_SEC:    rdata = cfg.cold_seconds;
      REG_WARM_SEC:    rdata = cfg.warm_seconds;
      REG_HOT_SEC:     rdata = cfg.hot_seconds;
      default:         rdata = 8'd0;
    endcase
  end

  assign prdata = {{(DATA_W-8){1'b0}}, rdata};

endmodule

[src/gars_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_step
// Next-state and action logic for one poll tick of the sequencer.
// ----------------------------------------------------------------------------
module gars_step (
  input  gars_pkg::cfg_t   cfg,
  input  gars_pkg::state_t cur,
  input  gars_pkg::tick_t  tk,
  output gars_pkg::state_t nxt,
  output gars_pkg::res_t   res
);
  import gars_pkg::*;

  logic [7:0] vc_inc;
  logic [7:0] ac_inc;
  logic [1:0] kind_sel;
  logic [7:0] kind_len;

  assign vc_inc = sat_inc(cur.verify_count);
  assign ac_inc = sat_inc(cur.acquire_count);

  // reset kind from the last sampled status
  always_comb begin
    if (cur.last_status[1:0] == 2'b00) begin
      kind_sel = KIND_COLD;
    end else if (mod3_zero(cur.last_status)) begin
      kind_sel = KIND_WARM;
    end else if (!cur.last_status[0]) begin
      kind_sel = KIND_HOT;
    end else begin
      kind_sel = cur.last_reset_kind;
    end
  end

  // timer length for the chosen kind
  always_comb begin
    case (kind_sel)
      KIND_COLD: kind_len = cfg.cold_seconds;
      KIND_WARM: kind_len = cfg.warm_seconds;
      default:   kind_len = cfg.hot_seconds;
    endcase
  end

  // phase transitions and strobes
  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_VERIFY: begin
        nxt.last_status = tk.receiver_status;
        if (tk.receiver_status == 8'd1) begin
          nxt.phase = PH_ACQUIRE;
        end else begin
          nxt.verify_count = vc_inc;
          if (vc_inc >= cfg.max_verify_retries) nxt.phase = PH_ERROR;
        end
      end
      PH_ACQUIRE: begin
        if (tk.acquire_ok) begin
          nxt.phase = PH_STORE;
        end else begin
          nxt.acquire_count = ac_inc;
          if (ac_inc > cfg.max_acquire_retries) nxt.phase = PH_ERROR;
        end
      end
      PH_STORE: begin
        if (tk.fix_nonzero) begin
          res.save_request = 1'b1;
          if (tk.store_ok) begin
            res.timer_start   = 1'b1;
            res.timer_length  = cfg.wait_seconds;
            nxt.phase         = PH_WAIT;
            nxt.verify_count  = 8'd0;
            nxt.acquire_count = 8'd0;
          end else begin
            nxt.phase = PH_ERROR;
          end
        end
      end
      PH_WAIT: begin
        if (tk.timer_done) begin
          res.power_on_pulse = 1'b1;
          nxt.phase          = PH_VERIFY;
        end
      end
      PH_ERROR: begin
        nxt.last_reset_kind = kind_sel;
        res.reset_request   = 1'b1;
        res.reset_kind      = kind_sel;
        res.timer_start     = 1'b1;
        res.timer_length    = kind_len;
        nxt.phase           = PH_WAIT;
      end
      default: begin
        nxt.phase = PH_VERIFY;
      end
    endcase
    res.state_code      = nxt.phase;
    res.verify_retries  = nxt.verify_count;
    res.acquire_retries = nxt.acquire_count;
  end

endmodule

[src/gars_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gars_chk
// Port-level checks on the sequencer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "gps_acquire_retry_sequencer_core_assert.svh"

module gars_chk (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] state_code,
  input logic       power_on_pulse,
  input logic       timer_start,
  input logic       reset_request,
  input logic [1:0] reset_kind
);
  import gars_pkg::*;

  // a receiver reset always starts its timer and lands in wait
  `GARS_ASSERT_NOW(a_reset_to_wait, res_valid && reset_request, timer_start && (state_code == PH_WAIT), "reset request without timer start or wait state")

  // no reset kind shown without a reset request
  `GARS_ASSERT_NOW(a_kind_quiet, res_valid && !reset_request, reset_kind == KIND_HOT, "reset kind set without reset request")

  // power-on only when returning to verify
  `GARS_ASSERT_NOW(a_power_verify, res_valid && power_on_pulse, state_code == PH_VERIFY, "power-on pulse outside return to verify")

  // stalled result holds
  `GARS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(state_code) && $stable(timer_start), "stalled result changed")

endmodule

bind gps_acquire_retry_sequencer_core gars_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .state_code     (result.state_code),
  .power_on_pulse (result.power_on_pulse),
  .timer_start    (result.timer_start),
  .reset_request  (result.reset_request),
  .reset_kind     (result.reset_kind)
);
